/* design/hfcd_pkg.sv */
// ----------------------------------------------------------------------------
// hfcd_pkg
// Frame constants, object ids, command values and state codes for the HMI
// frame command decoder.
// ----------------------------------------------------------------------------
package hfcd_pkg;

  // Frame layout
  localparam logic [7:0] HDR_FIRST   = 8'h5A;
  localparam logic [7:0] HDR_SECOND  = 8'hA5;
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  // Byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR2    = 4'd1;
  localparam logic [POS_W-1:0] POS_BODY    = 4'd2;
  localparam logic [POS_W-1:0] POS_ID_HIGH = 4'd4;
  localparam logic [POS_W-1:0] POS_ID_LOW  = 4'd5;

  // Object ids
  localparam logic [15:0] ID_SPEED  = 16'h1000;
  localparam logic [15:0] ID_ANGLE  = 16'h1001;
  localparam logic [15:0] ID_REPEAT = 16'h1002;
  localparam logic [15:0] ID_DWELL  = 16'h1003;
  localparam logic [15:0] ID_TORQUE = 16'h1100;
  localparam logic [15:0] ID_RUN    = 16'h3000;
  localparam logic [15:0] ID_RUN_EX = 16'h3100;
  localparam logic [15:0] ID_MODE   = 16'h4000;

  // Command values for the run-control ids
  localparam logic [7:0] CMD_START     = 8'd1;
  localparam logic [7:0] CMD_PAUSE     = 8'd2;
  localparam logic [7:0] CMD_STOP      = 8'd3;
  localparam logic [7:0] CMD_IDLE      = 8'd4;
  localparam logic [7:0] CMD_ESTOP     = 8'd5;
  localparam logic [7:0] CMD_ASSIST    = 8'd6;
  localparam logic [7:0] CMD_RESIST    = 8'd7;
  localparam logic [7:0] CMD_FORCE     = 8'd8;

  // Mode-select values
  localparam logic [7:0] MODE_SEL_ACTIVE  = 8'd1;
  localparam logic [7:0] MODE_SEL_PASSIVE = 8'd2;
  localparam logic [7:0] MODE_SEL_FORCE   = 8'd3;

  // Run state codes
  localparam logic [2:0] RUN_IDLE    = 3'd0;
  localparam logic [2:0] RUN_RUNNING = 3'd1;
  localparam logic [2:0] RUN_PAUSED  = 3'd2;
  localparam logic [2:0] RUN_STOP    = 3'd3;
  localparam logic [2:0] RUN_ESTOP   = 3'd4;

  // Top mode codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [1:0] MODE_PASSIVE = 2'd2;
  localparam logic [1:0] MODE_FORCE   = 2'd3;

  // Passive submode codes
  localparam logic SUB_ASSIST = 1'b0;
  localparam logic SUB_RESIST = 1'b1;

  // Reset values of the parameter registers
  localparam logic [7:0] SPEED_RST  = 8'd1;
  localparam logic [7:0] ANGLE_RST  = 8'd10;
  localparam logic [7:0] REPEAT_RST = 8'd10;
  localparam logic [7:0] DWELL_RST  = 8'd1;
  localparam logic [7:0] TORQUE_RST = 8'd30;

endpackage

/* design/hmi_frame_command_decoder_core.sv */
// A word accepted at a clock edge gives its result word in the following cycle.
// Throughput: one word per cycle; ready drops only while a result word waits unread.
// The frame tracker and settings registers update at the accept edge, so the result
// register stage is the settings registers themselves plus frame_done and the pulses.
// Reset (rst_ni, asynchronous, active low): hunt restarts, no result pending,
// settings return to speed 1, angle 10, repeat 10, dwell 1, torque 30, running, passive assist.
// ----------------------------------------------------------------------------
// hmi_frame_command_decoder_core
// Hunts for the 0x5A 0xA5 header in a byte stream, gathers nine-byte frames
// and applies the command carried by the object id and the last byte.
// ----------------------------------------------------------------------------
module hmi_frame_command_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_done_o,
  output logic [7:0] speed_value_o,
  output logic [7:0] angle_value_o,
  output logic [7:0] repeat_value_o,
  output logic [7:0] dwell_value_o,
  output logic [7:0] torque_value_o,
  output logic [2:0] run_state_o,
  output logic [1:0] top_mode_o,
  output logic       passive_submode_o,
  output logic       start_pulse_o,
  output logic       stop_pulse_o
);

  import hfcd_pkg::*;

  // Frame tracker
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       id_hi_q, id_hi_d;
  logic [7:0]       id_lo_q, id_lo_d;

  // Settings registers; these double as the result payload
  logic [7:0] speed_q, speed_d;
  logic [7:0] angle_q, angle_d;
  logic [7:0] repeat_q, repeat_d;
  logic [7:0] dwell_q, dwell_d;
  logic [7:0] torque_q, torque_d;
  logic [2:0] run_q, run_d;
  logic [1:0] mode_q, mode_d;
  logic       sub_q, sub_d;

  // Result handshake and per-word flags
  logic out_valid_q;
  logic done_q, done_d;
  logic start_q, start_d;
  logic stop_q, stop_d;

  logic             accept;
  logic [POS_W:0]   pos_inc;
  logic [15:0]      obj_id;

  // The result register frees up when empty or being read this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign obj_id  = {id_hi_q, id_lo_q};

  always_comb begin
    pos_d    = pos_q;
    id_hi_d  = id_hi_q;
    id_lo_d  = id_lo_q;
    speed_d  = speed_q;
    angle_d  = angle_q;
    repeat_d = repeat_q;
    dwell_d  = dwell_q;
    torque_d = torque_q;
    run_d    = run_q;
    mode_d   = mode_q;
    sub_d    = sub_q;
    done_d   = 1'b0;
    start_d  = 1'b0;
    stop_d   = 1'b0;

    if (pos_q == POS_HUNT) begin
      // Wait for the first header byte
      if (rx_byte_i == HDR_FIRST) begin
        pos_d = POS_HDR2;
      end
    end else if (pos_q == POS_HDR2) begin
      // Wrong second byte, a repeated 0x5A included, restarts the hunt
      pos_d = (rx_byte_i == HDR_SECOND) ? POS_BODY : POS_HUNT;
    end else begin
      // Capture the object id; other body bytes but the last are dropped
      if (pos_q == POS_ID_HIGH) begin
        id_hi_d = rx_byte_i;
      end else if (pos_q == POS_ID_LOW) begin
        id_lo_d = rx_byte_i;
      end
      pos_d = pos_inc[POS_W-1:0];
      // Last byte (or an out-of-range position) closes the frame
      if (pos_inc >= (POS_W+1)'(FRAME_BYTES)) begin
        done_d = 1'b1;
        pos_d  = POS_HUNT;
        case (obj_id)
          ID_SPEED:  speed_d  = rx_byte_i;
          ID_ANGLE:  angle_d  = rx_byte_i;
          ID_REPEAT: repeat_d = rx_byte_i;
          ID_DWELL:  dwell_d  = rx_byte_i;
          ID_TORQUE: torque_d = rx_byte_i;
          ID_RUN, ID_RUN_EX: begin
            case (rx_byte_i)
              CMD_START: begin
                run_d   = RUN_RUNNING;
                start_d = 1'b1;
              end
              CMD_PAUSE: run_d = RUN_PAUSED;
              CMD_STOP: begin
                run_d  = RUN_STOP;
                stop_d = 1'b1;
              end
              CMD_IDLE:  run_d = RUN_IDLE;
              CMD_ESTOP: run_d = RUN_ESTOP;
              // Mode changes are only valid on the extended run id
              CMD_ASSIST: begin
                if (obj_id == ID_RUN_EX) begin
                  mode_d = MODE_PASSIVE;
                  sub_d  = SUB_ASSIST;
                end
              end
              CMD_RESIST: begin
                if (obj_id == ID_RUN_EX) begin
                  mode_d = MODE_PASSIVE;
                  sub_d  = SUB_RESIST;
                end
              end
              CMD_FORCE: begin
                if (obj_id == ID_RUN_EX) begin
                  mode_d = MODE_FORCE;
                end
              end
              default: ;
            endcase
          end
          ID_MODE: begin
            case (rx_byte_i)
              MODE_SEL_ACTIVE:  mode_d = MODE_ACTIVE;
              MODE_SEL_PASSIVE: mode_d = MODE_PASSIVE;
              MODE_SEL_FORCE:   mode_d = MODE_FORCE;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HUNT;
      id_hi_q     <= 8'd0;
      id_lo_q     <= 8'd0;
      speed_q     <= SPEED_RST;
      angle_q     <= ANGLE_RST;
      repeat_q    <= REPEAT_RST;
      dwell_q     <= DWELL_RST;
      torque_q    <= TORQUE_RST;
      run_q       <= RUN_RUNNING;
      mode_q      <= MODE_PASSIVE;
      sub_q       <= SUB_ASSIST;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      start_q     <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      if (accept) begin
        // Advance state and load the result word together
        pos_q       <= pos_d;
        id_hi_q     <= id_hi_d;
        id_lo_q     <= id_lo_d;
        speed_q     <= speed_d;
        angle_q     <= angle_d;
        repeat_q    <= repeat_d;
        dwell_q     <= dwell_d;
        torque_q    <= torque_d;
        run_q       <= run_d;
        mode_q      <= mode_d;
        sub_q       <= sub_d;
        done_q      <= done_d;
        start_q     <= start_d;
        stop_q      <= stop_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_done_o      = done_q;
  assign speed_value_o     = speed_q;
  assign angle_value_o     = angle_q;
  assign repeat_value_o    = repeat_q;
  assign dwell_value_o     = dwell_q;
  assign torque_value_o    = torque_q;
  assign run_state_o       = run_q;
  assign top_mode_o        = mode_q;
  assign passive_submode_o = sub_q;
  assign start_pulse_o     = start_q;
  assign stop_pulse_o      = stop_q;

  // Pulses only ever accompany a completed frame
  a_pulse_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || stop_q) |-> done_q)
    else $error("command pulse without frame end");

  // Start and stop are mutually exclusive
  a_pulse_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_q && stop_q))
    else $error("start and stop pulses together");

  // The frame position never leaves the nine-byte window
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_inc < (POS_W+1)'(FRAME_BYTES + 1))
    else $error("frame position out of range");

  // A completed frame always returns the tracker to the hunt
  a_done_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_d) |=> (pos_q == POS_HUNT))
    else $error("frame end did not restart the hunt");

endmodule
